FILE: sv/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types and constants for the quadratic root solver pipeline.
// ----------------------------------------------------------------------------
package qrs_pkg;

    localparam int FRAC_BITS = 16;

    localparam int COEF_W    = 32;
    localparam int SQ_ROOT_W = 34;
    localparam int SQ_REM_W  = SQ_ROOT_W + 2;
    localparam int SQ_D_W    = 2 * SQ_ROOT_W;
    localparam int SQ_CELLS  = SQ_ROOT_W;
    localparam int NUM_W     = 36;
    localparam int NMAG_W    = NUM_W - 1 + FRAC_BITS;
    localparam int HI_W      = NMAG_W - COEF_W;
    localparam int DEN_W     = COEF_W + 1;
    localparam int DIV_CELLS = COEF_W;
    localparam int PIPE_LEN  = 2 + SQ_CELLS + 1 + DIV_CELLS;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_A_ZERO   = 2'd1;
    localparam logic [1:0] ST_NEG_DISC = 2'd2;

    localparam logic [COEF_W-1:0] Q_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic [COEF_W-1:0] Q_MIN = {1'b1, {(COEF_W-1){1'b0}}};

    typedef struct packed {
        logic [SQ_REM_W-1:0]  rem;
        logic [SQ_ROOT_W-1:0] root;
        logic [SQ_D_W-1:0]    dsh;
    } t_sq;

    typedef struct packed {
        logic [DEN_W-1:0]  rem;
        logic [COEF_W-1:0] q;
        logic [COEF_W-1:0] nlo;
        logic [DEN_W-1:0]  den;
    } t_dv;

    typedef struct packed {
        logic [COEF_W-1:0] a;
        logic [COEF_W-1:0] b;
        logic [1:0]        status;
    } t_sqm;

    typedef struct packed {
        logic [1:0] status;
        logic       neg_p;
        logic       neg_m;
        logic       big_p;
        logic       big_m;
    } t_dvm;

endpackage

FILE: sv/qrs_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qrs_sqrt_cell
// One restoring square root step: settles one root bit per cycle.
// ----------------------------------------------------------------------------
module qrs_sqrt_cell (
    input  logic        i_clk,
    input  qrs_pkg::t_sq i_d,
    output qrs_pkg::t_sq o_q
);
    import qrs_pkg::*;

    logic [SQ_REM_W+1:0] acc;
    logic [SQ_REM_W+1:0] sub;
    logic [SQ_REM_W+1:0] diff;
    logic                ge;

    always_comb begin
        acc  = {i_d.rem, i_d.dsh[SQ_D_W-1 -: 2]};
        sub  = {2'b00, i_d.root, 2'b01};
        diff = acc - sub;
        ge   = (acc >= sub);
    end

    always_ff @(posedge i_clk) begin
        o_q.rem  <= ge ? diff[SQ_REM_W-1:0] : acc[SQ_REM_W-1:0];
        o_q.root <= {i_d.root[SQ_ROOT_W-2:0], ge};
        o_q.dsh  <= {i_d.dsh[SQ_D_W-3:0], 2'b00};
    end

endmodule

FILE: sv/qrs_div_cell.sv
// ----------------------------------------------------------------------------
// qrs_div_cell
// One restoring division step: settles one quotient bit per cycle.
// ----------------------------------------------------------------------------
module qrs_div_cell (
    input  logic         i_clk,
    input  qrs_pkg::t_dv i_d,
    output qrs_pkg::t_dv o_q
);
    import qrs_pkg::*;

    logic [DEN_W:0] t;
    logic [DEN_W:0] d;
    logic [DEN_W:0] diff;
    logic           ge;

    always_comb begin
        t    = {i_d.rem, i_d.nlo[COEF_W-1]};
        d    = {1'b0, i_d.den};
        diff = t - d;
        ge   = (t >= d);
    end

    always_ff @(posedge i_clk) begin
        o_q.rem <= ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
        o_q.q   <= {i_d.q[COEF_W-2:0], ge};
        o_q.nlo <= {i_d.nlo[COEF_W-2:0], 1'b0};
        o_q.den <= i_d.den;
    end

endmodule

FILE: sv/quadratic_root_solver.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Real roots of a*x^2 + b*x + c in signed fixed point, fully pipelined.
// ----------------------------------------------------------------------------
//  channel   ports                                   handshake
//  command   i_coef_a, i_coef_b, i_coef_c            start, busy
//  result    o_root_plus, o_root_minus, o_status,    o_done
//            o_overflow
//
//  One transaction per cycle; busy stays low.
//  Stages: products and discriminant registers, 34 square root
//  cells (one root bit each), numerator setup, 32 divider cells, output.
//  Reset clears the valid pipeline only; results are never held off.
// ----------------------------------------------------------------------------
module quadratic_root_solver (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [31:0]         i_coef_a,
    input  logic signed [31:0]         i_coef_b,
    input  logic signed [31:0]         i_coef_c,
    output logic signed [31:0]         o_root_plus,
    output logic signed [31:0]         o_root_minus,
    output logic [1:0]                 o_status,
    output logic                       o_overflow,
    output logic                       o_done
);
    import qrs_pkg::*;

    function automatic logic [COEF_W:0] f_sat(input logic [COEF_W-1:0] q,
                                              input logic neg, input logic big);
        logic [COEF_W:0] r;
        if (big) begin
            r = {1'b1, neg ? Q_MIN : Q_MAX};
        end else if (!neg) begin
            r = q[COEF_W-1] ? {1'b1, Q_MAX} : {1'b0, q};
        end else begin
            r = (q > Q_MIN) ? {1'b1, Q_MIN} : {1'b0, ~q + 1'b1};
        end
        return r;
    endfunction

    logic [PIPE_LEN-1:0] r_vld;
    logic [COEF_W-1:0]   amag, bmag, cmag;

    logic [2*COEF_W-1:0] r1_bb, r1_p;
    logic                r1_n4, r1_az;
    logic [COEF_W-1:0]   r1_a, r1_b;

    logic [SQ_D_W-2:0]   p4, bbx, dsum;
    logic                dneg;
    logic [SQ_D_W-1:0]   r2_d;
    t_sqm                r2_m;

    t_sq                 w_sq [0:SQ_CELLS];
    t_sqm                r_sqm [0:SQ_CELLS-1];

    logic signed [NUM_W-1:0] bx, sx, np, nm, npa, nma;
    logic [NMAG_W-1:0]   nfp, nfm;
    logic [COEF_W-1:0]   am2;
    logic [DEN_W-1:0]    den;
    logic                bigp, bigm;
    t_sqm                sqm_l;

    t_dv                 w_dp [0:DIV_CELLS];
    t_dv                 w_dm [0:DIV_CELLS];
    t_dvm                r_dvm [0:DIV_CELLS];

    logic [COEF_W:0]     satp, satm;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            o_done <= 1'b0;
        end else begin
            r_vld  <= {r_vld[PIPE_LEN-2:0], start};
            o_done <= r_vld[PIPE_LEN-1];
        end
    end

    // products
    always_comb begin
        amag = i_coef_a[31] ? -i_coef_a : i_coef_a;
        bmag = i_coef_b[31] ? -i_coef_b : i_coef_b;
        cmag = i_coef_c[31] ? -i_coef_c : i_coef_c;
    end

    always_ff @(posedge i_clk) begin
        r1_bb <= bmag * bmag;
        r1_p  <= amag * cmag;
        r1_n4 <= (i_coef_a[31] != i_coef_c[31]) && (i_coef_c != '0);
        r1_az <= (i_coef_a == '0);
        r1_a  <= i_coef_a;
        r1_b  <= i_coef_b;
    end

    // discriminant
    always_comb begin
        p4   = {1'b0, r1_p, 2'b00};
        bbx  = {3'b000, r1_bb};
        dneg = !r1_n4 && (p4 > bbx);
        dsum = r1_n4 ? bbx + p4 : bbx - p4;
    end

    always_ff @(posedge i_clk) begin
        r2_d       <= {1'b0, dsum};
        r2_m.a     <= r1_a;
        r2_m.b     <= r1_b;
        r2_m.status <= r1_az ? ST_A_ZERO : (dneg ? ST_NEG_DISC : ST_OK);
    end

    // square root chain
    assign w_sq[0] = '{rem: '0, root: '0, dsh: r2_d};

    for (genvar k = 0; k < SQ_CELLS; k++) begin : g_sq
        qrs_sqrt_cell u_cell (.i_clk(i_clk), .i_d(w_sq[k]), .o_q(w_sq[k+1]));
        always_ff @(posedge i_clk) begin
            r_sqm[k] <= (k == 0) ? r2_m : r_sqm[(k == 0) ? 0 : k-1];
        end
    end

    // numerator setup
    always_comb begin
        sqm_l = r_sqm[SQ_CELLS-1];
        bx    = NUM_W'(signed'(sqm_l.b));
        sx    = signed'(NUM_W'(w_sq[SQ_CELLS].root));
        np    = sx - bx;
        nm    = -bx - sx;
        npa   = np[NUM_W-1] ? -np : np;
        nma   = nm[NUM_W-1] ? -nm : nm;
        nfp   = {npa[NUM_W-2:0], {FRAC_BITS{1'b0}}};
        nfm   = {nma[NUM_W-2:0], {FRAC_BITS{1'b0}}};
        am2   = sqm_l.a[COEF_W-1] ? -sqm_l.a : sqm_l.a;
        den   = {am2, 1'b0};
        bigp  = (66'(nfp[NMAG_W-1:COEF_W]) >= 66'(den));
        bigm  = (66'(nfm[NMAG_W-1:COEF_W]) >= 66'(den));
    end

    always_ff @(posedge i_clk) begin
        w_dp[0] <= '{rem: DEN_W'(nfp[NMAG_W-1:COEF_W]), q: '0,
                     nlo: nfp[COEF_W-1:0], den: den};
        w_dm[0] <= '{rem: DEN_W'(nfm[NMAG_W-1:COEF_W]), q: '0,
                     nlo: nfm[COEF_W-1:0], den: den};
        r_dvm[0] <= '{status: sqm_l.status,
                      neg_p: np[NUM_W-1] ^ sqm_l.a[COEF_W-1],
                      neg_m: nm[NUM_W-1] ^ sqm_l.a[COEF_W-1],
                      big_p: bigp, big_m: bigm};
    end

    // divider chains
    for (genvar k = 0; k < DIV_CELLS; k++) begin : g_dv
        qrs_div_cell u_p (.i_clk(i_clk), .i_d(w_dp[k]), .o_q(w_dp[k+1]));
        qrs_div_cell u_m (.i_clk(i_clk), .i_d(w_dm[k]), .o_q(w_dm[k+1]));
        always_ff @(posedge i_clk) begin
            r_dvm[k+1] <= r_dvm[k];
        end
    end

    // saturation and output
    always_comb begin
        satp = f_sat(w_dp[DIV_CELLS].q, r_dvm[DIV_CELLS].neg_p, r_dvm[DIV_CELLS].big_p);
        satm = f_sat(w_dm[DIV_CELLS].q, r_dvm[DIV_CELLS].neg_m, r_dvm[DIV_CELLS].big_m);
    end

    always_ff @(posedge i_clk) begin
        o_status <= r_dvm[DIV_CELLS].status;
        if (r_dvm[DIV_CELLS].status == ST_OK) begin
            o_root_plus  <= satp[COEF_W-1:0];
            o_root_minus <= satm[COEF_W-1:0];
            o_overflow   <= satp[COEF_W] | satm[COEF_W];
        end else begin
            o_root_plus  <= '0;
            o_root_minus <= '0;
            o_overflow   <= 1'b0;
        end
    end

`ifndef NO_ASSERTIONS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##(PIPE_LEN+1) o_done) else $error("result transaction missing");

    a_no_roots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OK) |->
            (o_root_plus == '0 && o_root_minus == '0 && !o_overflow))
        else $error("roots given without valid status");

    a_ovf_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_overflow) |->
            (o_root_plus == Q_MAX || o_root_plus == Q_MIN ||
             o_root_minus == Q_MAX || o_root_minus == Q_MIN))
        else $error("overflow without saturated root");
`endif

endmodule
